/* sv/lrufr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrufr_pkg
// Shared types and codes for the LRU frame replacement block.
// ----------------------------------------------------------------------------
package lrufr_pkg;

	localparam int unsigned ID_W     = 4;
	localparam int unsigned ID_SPACE = 1 << ID_W;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_ACCESS = 2'd1,
		OP_EVICT  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_UNTRACKED = 2'd2,
		ST_TRACKED   = 2'd3
	} status_t;

	// Command broadcast to every cell of the recency chain
	typedef struct packed {
		logic            create;
		logic            access;
		logic            evict;
		logic [ID_W-1:0] id;
	} cell_cmd_t;

endpackage
`default_nettype wire

/* sv/lrufr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrufr_cell
// One slot of the recency chain: holds a frame number and its valid bit.
// ----------------------------------------------------------------------------
module lrufr_cell
	import lrufr_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cell_cmd_t       cmd,
	input  wire logic            prev_valid,
	input  wire logic            next_valid,
	input  wire logic [ID_W-1:0] next_id,
	input  wire logic            hit_in,
	output      logic            hit_out,
	output      logic            valid,
	output      logic [ID_W-1:0] id
);

	logic            valid_q;
	logic [ID_W-1:0] id_q;
	logic            match;
	logic            hit;

	always_comb begin
		match   = valid_q && (id_q == cmd.id);
		hit     = hit_in || match;
		hit_out = hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.create && prev_valid && !valid_q) begin
			valid_q <= 1'b1;
		end else if (cmd.evict) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create && prev_valid && !valid_q) begin
			// first free slot takes the new frame
			id_q <= cmd.id;
		end else if (cmd.access && hit && valid_q) begin
			// at or past the hit: pull from the neighbor, the last slot takes the id
			id_q <= next_valid ? next_id : cmd.id;
		end else if (cmd.evict) begin
			id_q <= next_id;
		end
	end

	assign valid = valid_q;
	assign id    = id_q;

endmodule
`default_nettype wire

/* sv/lru_frame_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none
// A result is registered and offered in the cycle after its input transfer.
// Throughput: one event per cycle while results are taken; the output register
//   frees as it is read, so input is accepted in the same cycle the result drains.
// The access search ripples a hit flag combinationally through all FRAMES cells.
// Reset clears the tracked marks, the cell valid bits and the output valid flag;
//   frame numbers in the cells are not reset and are read only once written.
// ----------------------------------------------------------------------------
// lru_frame_replacement
// Least-recently-used order over buffer frames kept in a chain of cells.
// ----------------------------------------------------------------------------
module lru_frame_replacement
	import lrufr_pkg::*;
#(
	parameter int unsigned FRAMES = 16
)(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output      logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [3:0] frame_id, [7:4] zero
	input  wire logic [1:0] s_tuser,   // [1:0] op
	output      logic       m_tvalid,
	input  wire logic       m_tready,
	output      logic [7:0] m_tdata,   // [3:0] victim_id, [7:4] zero
	output      logic [1:0] m_tuser    // [1:0] status
);

	// Chain wiring: index FRAMES is the empty neighbor past the last cell
	logic            cell_valid [FRAMES+1];
	logic [ID_W-1:0] cell_id    [FRAMES+1];
	logic            hit_chain  [FRAMES+1];

	// Tracked marks, one per possible frame number
	logic [ID_SPACE-1:0] mark_q;

	// Output register
	logic            out_valid_q;
	status_t         status_q;
	logic [ID_W-1:0] victim_q;

	// Decode of the incoming event
	op_t             op;
	logic [ID_W-1:0] fid;
	logic            in_xfer;
	logic            id_ok;
	logic            full;
	logic            empty;
	cell_cmd_t       cmd;
	status_t         status_d;
	logic [ID_W-1:0] victim_d;

	assign cell_valid[FRAMES] = 1'b0;
	assign cell_id[FRAMES]    = '0;
	assign hit_chain[0]       = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < FRAMES; gi++) begin : g_cell
			logic prev_valid;
			if (gi == 0) begin : g_head
				assign prev_valid = 1'b1;
			end else begin : g_body
				assign prev_valid = cell_valid[gi-1];
			end
			lrufr_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.prev_valid (prev_valid),
				.next_valid (cell_valid[gi+1]),
				.next_id    (cell_id[gi+1]),
				.hit_in     (hit_chain[gi]),
				.hit_out    (hit_chain[gi+1]),
				.valid      (cell_valid[gi]),
				.id         (cell_id[gi])
			);
		end
	endgenerate

	// Accept while the output register is free or being drained this cycle
	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	always_comb begin
		op       = op_t'(s_tuser);
		fid      = s_tdata[ID_W-1:0];
		id_ok    = 32'(fid) < FRAMES;
		full     = cell_valid[FRAMES-1];
		empty    = !cell_valid[0];
		cmd      = '0;
		cmd.id   = fid;
		status_d = ST_OK;
		victim_d = '0;
		case (op)
			OP_CREATE: begin
				if (!id_ok) begin
					status_d = ST_UNTRACKED;
				end else if (mark_q[fid]) begin
					status_d = ST_TRACKED;
				end else begin
					// a create into a full order answers ok and changes nothing
					cmd.create = in_xfer && !full;
				end
			end
			OP_ACCESS: begin
				if (!id_ok || !mark_q[fid]) begin
					status_d = ST_UNTRACKED;
				end else begin
					cmd.access = in_xfer;
				end
			end
			OP_EVICT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					victim_d  = cell_id[0];
					cmd.evict = in_xfer;
				end
			end
			default: begin
				// unused code: answer ok, change nothing
				status_d = ST_OK;
			end
		endcase
	end

	// Hold tracked marks: set on create, drop on evict of the victim
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (cmd.create) begin
			mark_q[fid] <= 1'b1;
		end else if (cmd.evict) begin
			mark_q[victim_d] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q <= status_d;
			victim_q <= victim_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8-ID_W){1'b0}}, victim_q};
	assign m_tuser  = status_q;

endmodule
`default_nettype wire

/* sv/lrufr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrufr_checker
// Port-level checks for the LRU frame replacement block.
// ----------------------------------------------------------------------------
module lrufr_checker
	import lrufr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [1:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser
);

	// Every input transfer produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after input transfer");

	// Only an ok result may carry a victim number
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == 8'd0))
		else $error("victim set on a failed event");

	// A non-evict event never names a victim
	a_evict_only: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != OP_EVICT) |=> (m_tdata == 8'd0))
		else $error("victim set on a non-evict event");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind lru_frame_replacement lrufr_checker u_lrufr_checker (.*);
`default_nettype wire

/* dv/tb_lru_frame_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_frame_replacement
// Self-checking bench for the LRU frame replacement block. A behavioral copy
// of the recency order predicts the status and victim of every event. Both
// stream sides idle at random. Directed events hit the corner cases first,
// and then random fill, access and evict traffic follows.
// ----------------------------------------------------------------------------
module tb_lru_frame_replacement;
	import lrufr_pkg::*;

	localparam int FRAMES      = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] victim;
	} lru_result_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [3:0] frame_id, [7:4] zero
	logic [1:0] s_tuser;    // [1:0] op
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [3:0] victim_id, [7:4] zero
	logic [1:0] m_tuser;    // [1:0] status

	// Predicted recency order: slot 0 is least recent
	logic [ID_W-1:0] recency[FRAMES];
	bit              tracked[FRAMES];
	int              occupancy;
	int              peak_occupancy;

	lru_result_t     pending_results[$];
	int              transfers_sent;
	int              events_sent;
	int              results_seen;
	int              mismatch_count;
	int              status_tally[4];
	int              cycle_count;
	bit              no_idle;

	lru_frame_replacement #(.FRAMES(FRAMES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out after %0d cycles", $time, cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	// Apply one event to the predicted order and return its result
	task automatic predict_lru_event(input op_t op, input logic [ID_W-1:0] frame,
			output lru_result_t res);
		int pos;
		int i;
		res.status = ST_OK;
		res.victim = '0;
		case (op)
			OP_CREATE: begin
				if (int'(frame) >= FRAMES) begin
					res.status = ST_UNTRACKED;
				end else if (tracked[frame]) begin
					res.status = ST_TRACKED;
				end else if (occupancy < FRAMES) begin
					recency[occupancy] = frame;
					occupancy++;
					tracked[frame] = 1'b1;
				end
			end
			OP_ACCESS: begin
				if (int'(frame) >= FRAMES || !tracked[frame]) begin
					res.status = ST_UNTRACKED;
				end else begin
					pos = 0;
					while (pos < occupancy && recency[pos] != frame)
						pos++;
					if (pos < occupancy) begin
						// Close the gap, then put the frame at the most recent end
						for (i = pos; i + 1 < occupancy; i++)
							recency[i] = recency[i + 1];
						recency[occupancy - 1] = frame;
					end
				end
			end
			OP_EVICT: begin
				if (occupancy == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.victim = recency[0];
					for (i = 0; i + 1 < occupancy; i++)
						recency[i] = recency[i + 1];
					occupancy--;
					tracked[res.victim] = 1'b0;
				end
			end
			default: begin
				// Unused code: no change, plain ok
			end
		endcase
		if (occupancy > peak_occupancy)
			peak_occupancy = occupancy;
		status_tally[res.status]++;
	endtask

	// Check output transfers against the oldest prediction, and predict
	// each input transfer as it is taken
	always @(posedge clk) begin
		lru_result_t want;
		lru_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.status = status_t'(m_tuser);
				got.victim = m_tdata[ID_W-1:0];
				if (pending_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual status %0d victim %0d",
						$time, got.status, got.victim);
				end else begin
					want = pending_results.pop_front();
					if (got.status != want.status) begin
						mismatch_count++;
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.victim != want.victim) begin
						mismatch_count++;
						$display("%0t: victim_id mismatch, expected %0d actual %0d",
							$time, want.victim, got.victim);
					end
					if (m_tdata[7:ID_W] != '0) begin
						mismatch_count++;
						$display("%0t: tdata padding mismatch, expected 0 actual %0h",
							$time, m_tdata[7:ID_W]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_lru_event(op_t'(s_tuser), s_tdata[ID_W-1:0], want);
				pending_results.push_back(want);
			end
		end
	end

	// Result side: stall a random number of cycles before taking each result
	initial begin
		int stall;
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offer one event after a random gap and hold it until the transfer;
	// valid stays high into the next event when no gap is drawn
	task automatic send_lru_event(input op_t op, input logic [ID_W-1:0] frame);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(8 - ID_W){1'b0}}, frame};
		do @(posedge clk); while (!s_tready);
		transfers_sent++;
		if (op != OP_NONE)
			events_sent++;
	endtask

	// Hold off input until every outstanding result has been taken;
	// wait on the clock first so the next offer never lands in the same step
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_seen < transfers_sent)
			@(posedge clk);
	endtask

	task automatic test_empty_evict();
		send_lru_event(OP_EVICT, 4'd0);
		send_lru_event(OP_EVICT, 4'd15);
	endtask

	task automatic test_create_and_duplicate();
		send_lru_event(OP_CREATE, 4'd0);
		send_lru_event(OP_CREATE, 4'd15);
		send_lru_event(OP_CREATE, 4'd0);
	endtask

	// Touch the most recent frame, move the front, miss, add a frame, move the front again
	task automatic test_access_order();
		send_lru_event(OP_ACCESS, 4'd15);
		send_lru_event(OP_ACCESS, 4'd0);
		send_lru_event(OP_ACCESS, 4'd7);
		send_lru_event(OP_CREATE, 4'd10);
		send_lru_event(OP_ACCESS, 4'd15);
	endtask

	task automatic test_ignored_op();
		send_lru_event(OP_NONE, 4'd15);
		send_lru_event(OP_NONE, 4'd0);
	endtask

	// Empty the order, then check a create after that becomes the only entry
	task automatic test_evict_to_empty();
		repeat (4) send_lru_event(OP_EVICT, 4'd0);
		send_lru_event(OP_CREATE, 4'd5);
		send_lru_event(OP_EVICT, 4'd0);
	endtask

	// Create every frame in shuffled order, touch a few, then drain past empty
	task automatic run_fill_and_drain();
		logic [ID_W-1:0] ids[FRAMES];
		logic [ID_W-1:0] tmp;
		int j;
		int k;
		for (j = 0; j < FRAMES; j++)
			ids[j] = j[ID_W-1:0];
		for (j = FRAMES - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = ids[j];
			ids[j] = ids[k];
			ids[k] = tmp;
		end
		for (j = 0; j < FRAMES; j++)
			send_lru_event(OP_CREATE, ids[j]);
		send_lru_event(OP_CREATE, ids[$urandom_range(0, FRAMES - 1)]);
		repeat ($urandom_range(1, 6))
			send_lru_event(OP_ACCESS, 4'($urandom_range(0, FRAMES - 1)));
		repeat (FRAMES + 1)
			send_lru_event(OP_EVICT, 4'($urandom));
	endtask

	// Creates and accesses of tracked frames, with evicts and noise
	task automatic run_mixed_events();
		int n;
		int pick;
		logic [ID_W-1:0] frame;
		n = $urandom_range(8, 24);
		repeat (n) begin
			pick  = $urandom_range(0, 99);
			frame = 4'($urandom);
			if (pick < 35) begin
				send_lru_event(OP_CREATE, frame);
			end else if (pick < 70) begin
				if (occupancy > 0)
					frame = recency[$urandom_range(0, occupancy - 1)];
				send_lru_event(OP_ACCESS, frame);
			end else if (pick < 92) begin
				send_lru_event(OP_EVICT, frame);
			end else if (pick < 97) begin
				send_lru_event(OP_ACCESS, frame);
			end else begin
				send_lru_event(OP_NONE, frame);
			end
		end
	endtask

	task automatic test_random_traffic(input int target);
		int kind;
		while (events_sent < target) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 2)
				run_fill_and_drain();
			else if (kind < 9)
				run_mixed_events();
			else
				wait_results_drained();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		int j;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_NONE;
		m_tready = 1'b0;
		no_idle  = 1'b0;
		occupancy      = 0;
		peak_occupancy = 0;
		transfers_sent = 0;
		events_sent    = 0;
		results_seen   = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		for (j = 0; j < FRAMES; j++) begin
			tracked[j] = 1'b0;
			recency[j] = '0;
		end
		for (j = 0; j < 4; j++)
			status_tally[j] = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_evict();
		test_create_and_duplicate();
		test_access_order();
		test_ignored_op();
		wait_results_drained();
		test_evict_to_empty();
		test_random_traffic(1000);

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("%0t: results left over, expected 0 actual %0d",
				$time, pending_results.size());
		end

		$display("Ran %0d events in %0d transfers; peak of %0d tracked frames.",
			events_sent, transfers_sent, peak_occupancy);
		$display("Statuses: ok %0d, empty %0d, untracked %0d, already tracked %0d.",
			status_tally[ST_OK], status_tally[ST_EMPTY],
			status_tally[ST_UNTRACKED], status_tally[ST_TRACKED]);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
sv/lrufr_pkg.sv
sv/lrufr_cell.sv
sv/lru_frame_replacement.sv
sv/lrufr_checker.sv
dv/tb_lru_frame_replacement.sv
